// ----- rtl/core/mhpq_pkg.sv -----
// Shared types and constants of the min-heap priority queue.
package mhpq_pkg;

  localparam int unsigned Capacity    = 64;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned CntW        = $clog2(Capacity + 1);
  localparam int unsigned EntryCountW = 7;
  localparam int unsigned StatusW     = 2;

  typedef enum logic {
    CmdRemove = 1'b0,
    CmdInsert = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  // Operation broadcast to every cell
  typedef struct packed {
    logic                   ins_en;
    logic                   rem_en;
    logic signed [KeyW-1:0] key;
  } ctrl_t;

  // Handed from each cell to its right neighbour
  typedef struct packed {
    logic                   take;
    logic signed [KeyW-1:0] key;
  } link_t;

endpackage

// ----- rtl/core/mhpq_cell.sv -----
// One cell of the sorted key row: holds one key, shifts right on insert, left on remove.
module mhpq_cell (
  input  logic                             clk_i,
  input  mhpq_pkg::ctrl_t                  ctrl_i,
  input  logic                             in_use_i,
  input  mhpq_pkg::link_t                  left_i,
  input  logic signed [mhpq_pkg::KeyW-1:0] right_key_i,
  output mhpq_pkg::link_t                  right_o,
  output logic signed [mhpq_pkg::KeyW-1:0] key_o
);

  logic signed [mhpq_pkg::KeyW-1:0] key_q, key_d;
  logic                             take;

  // Cell gives way when it is empty or the new key sorts before it
  assign take = !in_use_i || (ctrl_i.key < key_q);

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins_en) begin
      if (take) begin
        key_d = left_i.take ? left_i.key : ctrl_i.key;
      end
    end else if (ctrl_i.rem_en) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign right_o.take = take;
  assign right_o.key  = key_q;
  assign key_o        = key_q;

endmodule

// ----- rtl/core/min_heap_priority_queue_core.sv -----
// Top level of the priority queue: command handling, entry count and row of key cells.
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+-----------------------------------
//   in      | input     | in_valid_i/in_stall_o   | cmd_i, key_in_i
//   out     | output    | out_valid_o/out_stall_i | min_key_o, status_o, entry_count_o
//
// All cells compare the key at once and shift on the same edge. The result is registered
// on the accepting edge and offered from the next cycle.
// A new item is taken whenever the result register is free or being emptied.
// Reset clears the entry count and the result valid flag; the cells are not reset.
// While out_stall_i holds a waiting result, in_stall_o is raised.
module min_heap_priority_queue_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    cmd_i,
  input  logic signed [mhpq_pkg::KeyW-1:0]        key_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [mhpq_pkg::KeyW-1:0]        min_key_o,
  output logic        [mhpq_pkg::StatusW-1:0]     status_o,
  output logic        [mhpq_pkg::EntryCountW-1:0] entry_count_o
);

  logic [mhpq_pkg::CntW-1:0]          count_q, count_d;
  logic                               out_valid_q;
  logic signed [mhpq_pkg::KeyW-1:0]   min_key_q, min_key_d;
  logic [mhpq_pkg::StatusW-1:0]       status_q, status_d;
  logic                               accept;
  logic                               is_full, is_empty;
  mhpq_pkg::ctrl_t                    ctrl;
  mhpq_pkg::link_t                    link [mhpq_pkg::Capacity+1];
  logic signed [mhpq_pkg::KeyW-1:0]   key  [mhpq_pkg::Capacity+1];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_full    = (count_q == mhpq_pkg::CntW'(mhpq_pkg::Capacity));
  assign is_empty   = (count_q == '0);

  assign ctrl.ins_en = accept && (cmd_i == mhpq_pkg::CmdInsert) && !is_full;
  assign ctrl.rem_en = accept && (cmd_i == mhpq_pkg::CmdRemove) && !is_empty;
  assign ctrl.key    = key_in_i;

  assign link[0]                  = '{take: 1'b0, key: '0};
  assign key[mhpq_pkg::Capacity]  = '0;

  for (genvar i = 0; i < mhpq_pkg::Capacity; i++) begin : g_cell
    mhpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .in_use_i    (mhpq_pkg::CntW'(i) < count_q),
      .left_i      (link[i]),
      .right_key_i (key[i+1]),
      .right_o     (link[i+1]),
      .key_o       (key[i])
    );
  end

  always_comb begin
    count_d   = count_q;
    min_key_d = '0;
    status_d  = mhpq_pkg::StatusOk;
    if (cmd_i == mhpq_pkg::CmdInsert) begin
      if (is_full) begin
        status_d = mhpq_pkg::StatusFull;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_d = mhpq_pkg::StatusEmpty;
      end else begin
        count_d   = count_q - 1'b1;
        min_key_d = key[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_key_q <= min_key_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign min_key_o     = min_key_q;
  assign status_o      = status_q;
  assign entry_count_o = mhpq_pkg::EntryCountW'(count_q);

endmodule

// ----- tb/tb_min_heap_priority_queue_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the min-heap priority queue core: directed table, then random commands.
module tb_min_heap_priority_queue_core;
  import mhpq_pkg::*;

  typedef logic signed [KeyW-1:0] key_t;

  typedef struct packed {
    key_t                   min_key;
    status_e                status;
    logic [EntryCountW-1:0] entry_count;
  } result_t;

  typedef struct packed {
    cmd_e    cmd;
    key_t    key;
    logic    typed;
    result_t typed_res;
  } row_t;

  localparam int      NoAcceptLimit = 2000;
  localparam int      DrainCycles   = 16;
  localparam key_t    KeyMax        = 32'sh7fffffff;
  localparam key_t    KeyMin        = 32'sh80000000;
  localparam result_t NoCheck       = '0;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic                   cmd_i       = 1'b0;
  key_t                   key_in_i    = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  key_t                   min_key_o;
  logic [StatusW-1:0]     status_o;
  logic [EntryCountW-1:0] entry_count_o;

  key_t        heap_keys [1:Capacity];
  int unsigned heap_count = 0;
  result_t     pending_results [$];
  int          mismatches = 0;
  int          idle_run   = 0;
  logic        quiet      = 1'b0;

  // extremes, removal from empty, ties and ignored keys on removal
  row_t directed_rows [0:24] = '{
    '{CmdRemove, 32'sd0,  1'b1, '{32'sd0, StatusEmpty, 7'd0}},
    '{CmdRemove, -32'sd1, 1'b1, '{32'sd0, StatusEmpty, 7'd0}},
    '{CmdInsert, KeyMax,  1'b1, '{32'sd0, StatusOk, 7'd1}},
    '{CmdRemove, 32'sd0,  1'b1, '{KeyMax, StatusOk, 7'd0}},
    '{CmdInsert, KeyMin,  1'b1, '{32'sd0, StatusOk, 7'd1}},
    '{CmdInsert, KeyMax,  1'b1, '{32'sd0, StatusOk, 7'd2}},
    '{CmdRemove, KeyMax,  1'b1, '{KeyMin, StatusOk, 7'd1}},
    '{CmdRemove, 32'sd0,  1'b1, '{KeyMax, StatusOk, 7'd0}},
    '{CmdInsert, 32'sd5,  1'b0, NoCheck},
    '{CmdInsert, 32'sd5,  1'b0, NoCheck},
    '{CmdInsert, -32'sd3, 1'b0, NoCheck},
    '{CmdInsert, 32'sd0,  1'b0, NoCheck},
    '{CmdInsert, -32'sd1, 1'b0, NoCheck},
    '{CmdInsert, 32'sd5,  1'b0, NoCheck},
    '{CmdInsert, KeyMax,  1'b0, NoCheck},
    '{CmdInsert, KeyMin,  1'b0, NoCheck},
    '{CmdRemove, 32'sd0,  1'b1, '{KeyMin, StatusOk, 7'd7}},
    '{CmdRemove, 32'sd0,  1'b0, NoCheck},
    '{CmdRemove, 32'sd0,  1'b0, NoCheck},
    '{CmdRemove, 32'sd0,  1'b0, NoCheck},
    '{CmdRemove, 32'sd0,  1'b0, NoCheck},
    '{CmdRemove, 32'sd0,  1'b0, NoCheck},
    '{CmdRemove, 32'sd0,  1'b0, NoCheck},
    '{CmdRemove, 32'sd0,  1'b0, NoCheck},
    '{CmdRemove, 32'sd0,  1'b1, '{32'sd0, StatusEmpty, 7'd0}}
  };

  min_heap_priority_queue_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .key_in_i      (key_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .min_key_o     (min_key_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic result_t heap_apply(cmd_e c, key_t k);
    result_t     r;
    int unsigned pos;
    int unsigned pick;
    key_t        t;
    r = NoCheck;
    r.status = StatusOk;
    if (c == CmdInsert) begin
      if (heap_count >= Capacity) begin
        r.status = StatusFull;
      end else begin
        heap_count++;
        heap_keys[heap_count] = k;
        pos = heap_count;
        while (pos > 1 && heap_keys[pos / 2] > heap_keys[pos]) begin
          t = heap_keys[pos / 2];
          heap_keys[pos / 2] = heap_keys[pos];
          heap_keys[pos] = t;
          pos = pos / 2;
        end
      end
    end else if (heap_count == 0) begin
      r.status = StatusEmpty;
    end else begin
      r.min_key = heap_keys[1];
      heap_keys[1] = heap_keys[heap_count];
      heap_count--;
      pos = 1;
      while (2 * pos <= heap_count) begin
        pick = 2 * pos;
        if (pick + 1 <= heap_count && heap_keys[pick + 1] < heap_keys[pick]) pick++;
        if (heap_keys[pos] <= heap_keys[pick]) break;
        t = heap_keys[pos];
        heap_keys[pos] = heap_keys[pick];
        heap_keys[pick] = t;
        pos = pick;
      end
    end
    r.entry_count = EntryCountW'(heap_count);
    return r;
  endfunction

  function automatic key_t pick_key();
    key_t k;
    case ($urandom_range(0, 9))
      0, 1, 2: k = key_t'($urandom);
      3, 4, 5: k = key_t'(int'($urandom_range(0, 16)) - 8);
      6: begin
        case ($urandom_range(0, 3))
          0: k = KeyMax;
          1: k = KeyMin;
          2: k = '0;
          default: k = -32'sd1;
        endcase
      end
      default: k = key_t'(int'($urandom_range(0, 2000)) - 1000);
    endcase
    return k;
  endfunction

  function automatic cmd_e pick_cmd(int insert_pct);
    return ($urandom_range(0, 99) < insert_pct) ? CmdInsert : CmdRemove;
  endfunction

  task automatic send_cmd(input cmd_e c, input key_t k, input logic typed,
                          input result_t typed_res);
    result_t r;
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    key_in_i   <= k;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = heap_apply(c, k);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic run_mixed(input int n, input int insert_pct);
    repeat (n) send_cmd(pick_cmd(insert_pct), pick_key(), 1'b0, NoCheck);
  endtask

  // fill to capacity, then send mostly inserts to hit the full case
  task automatic run_fill();
    while (heap_count < Capacity) send_cmd(pick_cmd(90), pick_key(), 1'b0, NoCheck);
    repeat (6) send_cmd(pick_cmd(80), pick_key(), 1'b0, NoCheck);
  endtask

  task automatic run_drain();
    while (heap_count > 0) send_cmd(pick_cmd(10), pick_key(), 1'b0, NoCheck);
    repeat (6) send_cmd(pick_cmd(20), pick_key(), 1'b0, NoCheck);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].typed,
               directed_rows[i].typed_res);
    end
    run_mixed(160, 55);
    run_fill();
    run_drain();
    quiet <= 1'b1;
    run_mixed(120, 50);
    quiet <= 1'b0;
    run_mixed(80, 45);
    run_fill();
    run_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 9);
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected item: min_key %0d status %0d count %0d",
                   min_key_o, status_o, entry_count_o);
        end
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (min_key_o !== want.min_key || status_o !== want.status ||
            entry_count_o !== want.entry_count) begin
          if (mismatches < 10) begin
            $display("mismatch: min_key %0d/%0d status %0d/%0d count %0d/%0d (exp/act)",
                     want.min_key, min_key_o, want.status, status_o,
                     want.entry_count, entry_count_o);
          end
          mismatches++;
        end
      end
    end
  end

  // no progress on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_run <= 0;
    end else if (idle_run >= NoAcceptLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

endmodule
